/* src/mpqik_pkg.sv */
package mpqik_pkg;

  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int KEY_W    = 32;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_EXTRACT  = 2'd1;
  localparam logic [1:0] CMD_INCREASE = 2'd2;
  localparam logic [1:0] CMD_NOP      = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] value;
    logic [SLOT_W-1:0]       slot;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       handle;
    logic signed [KEY_W-1:0] result_value;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] top_value;
    logic [COUNT_W-1:0]      entry_total;
    logic                    is_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_APPLY,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic op_exec;
    logic inc_apply;
    logic scan_run;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic is_inc;
  } dp_sts_t;

endpackage

/* src/mpqik_ctrl.sv */
module mpqik_ctrl
  import mpqik_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_EXEC;
      S_EXEC:  state_next = sts.is_inc ? S_APPLY : S_SCAN;
      S_APPLY: state_next = S_SCAN;
      S_SCAN:  if (sts.scan_last) state_next = S_DONE;
      S_DONE:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC:  cmd.op_exec = 1'b1;
      S_APPLY: cmd.inc_apply = 1'b1;
      S_SCAN:  cmd.scan_run = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/mpqik_dp.sv */
module mpqik_dp
  import mpqik_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  // Each entry holds a used flag above the key.
  logic [KEY_W:0] mem [CAPACITY];
  logic [KEY_W:0] rdata;

  logic                    we;
  logic [SLOT_W-1:0]       waddr;
  logic [KEY_W:0]          wdata;
  logic [SLOT_W-1:0]       raddr;

  logic [SLOT_W:0]         cnt;
  logic                    rd_vld;
  logic [SLOT_W-1:0]       rd_idx;

  in_item_t                req;
  logic [COUNT_W-1:0]      count;
  logic                    top_found;
  logic [SLOT_W-1:0]       top_idx;
  logic signed [KEY_W-1:0] top_key;
  logic                    free_found;
  logic [SLOT_W-1:0]       free_idx;

  logic [SLOT_W-1:0]       handle;
  logic signed [KEY_W-1:0] result_value;
  logic [1:0]              status;

  logic                    inc_ok;
  logic                    scan_start;

  assign inc_ok     = rdata[KEY_W] && (req.value >= $signed(rdata[KEY_W-1:0]));
  assign scan_start = (cmd.op_exec && !sts.is_inc) || cmd.inc_apply;

  assign sts.clr_last  = (cnt[SLOT_W-1:0] == SLOT_W'(CAPACITY - 1));
  assign sts.scan_last = rd_vld && (rd_idx == SLOT_W'(CAPACITY - 1));
  assign sts.is_inc    = (req.cmd == CMD_INCREASE);

  always_comb begin
    we    = 1'b0;
    waddr = cnt[SLOT_W-1:0];
    wdata = '0;
    raddr = cmd.scan_run ? cnt[SLOT_W-1:0] : req.slot;
    if (cmd.clr) begin
      we = 1'b1;
    end else if (cmd.op_exec) begin
      if (req.cmd == CMD_INSERT && free_found) begin
        we    = 1'b1;
        waddr = free_idx;
        wdata = {1'b1, req.value};
      end else if (req.cmd == CMD_EXTRACT && top_found) begin
        we    = 1'b1;
        waddr = top_idx;
        wdata = {1'b0, top_key};
      end
    end else if (cmd.inc_apply && inc_ok) begin
      we    = 1'b1;
      waddr = req.slot;
      wdata = {1'b1, req.value};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_vld     <= 1'b0;
      count      <= '0;
      top_found  <= 1'b0;
      free_found <= 1'b1;
      free_idx   <= '0;
    end else begin
      rd_vld <= cmd.scan_run && !cnt[SLOT_W];
      if (cmd.clr) begin
        cnt <= cnt + 1'b1;
      end else if (scan_start) begin
        cnt        <= '0;
        top_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan_run && !cnt[SLOT_W]) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.op_exec) begin
        if (req.cmd == CMD_INSERT && free_found) begin
          count <= count + 1'b1;
        end else if (req.cmd == CMD_EXTRACT && top_found) begin
          count <= count - 1'b1;
        end
      end
      if (rd_vld) begin
        if (rdata[KEY_W]) begin
          if (!top_found || $signed(rdata[KEY_W-1:0]) > top_key) begin
            top_found <= 1'b1;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run) begin
      rd_idx <= cnt[SLOT_W-1:0];
    end
    if (rd_vld && rdata[KEY_W]
        && (!top_found || $signed(rdata[KEY_W-1:0]) > top_key)) begin
      top_idx <= rd_idx;
      top_key <= $signed(rdata[KEY_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op_exec) begin
      handle       <= '0;
      result_value <= '0;
      status       <= ST_DONE;
      case (req.cmd)
        CMD_INSERT: begin
          if (free_found) begin
            handle <= free_idx;
          end else begin
            status <= ST_FULL;
          end
        end
        CMD_EXTRACT: begin
          if (top_found) begin
            handle       <= top_idx;
            result_value <= top_key;
          end else begin
            result_value <= '1;
            status       <= ST_EMPTY;
          end
        end
        CMD_INCREASE: handle <= req.slot;
        default: handle <= '0;
      endcase
    end else if (cmd.inc_apply) begin
      status <= inc_ok ? ST_DONE : ST_IGNORED;
    end
  end

  assign out_data.handle       = handle;
  assign out_data.result_value = result_value;
  assign out_data.status       = status;
  assign out_data.top_value    = top_found ? top_key : '1;
  assign out_data.entry_total  = count;
  assign out_data.is_empty     = (count == '0);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.op_exec && req.cmd == CMD_INSERT && free_found)
      |=> count == $past(count) + 1'b1)
    else $error("insert did not raise the count");

  a_extract_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.op_exec && req.cmd == CMD_EXTRACT && top_found)
      |=> count == $past(count) - 1'b1)
    else $error("extract did not lower the count");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (sts.scan_last && count == '0) |=> !top_found)
    else $error("empty queue reports a top entry");
`endif

endmodule

/* src/max_priority_queue_increase_key.sv */
// Bounded max-priority queue of 1024 signed 32-bit keys with slot handles.
// After reset the block runs a clearing pass over its entry memory and
// accepts no transaction until it ends. Each accepted transaction first
// applies its command (increase-key then takes an extra step that checks
// and rewrites the addressed entry), then sweeps the single entry memory,
// one entry a cycle through a registered read, to find the new maximum and
// the lowest free slot for the next insert, and then presents its result.
// One transaction is in work at a time; the next is accepted at the
// earliest in the cycle after the result has been taken.
module max_priority_queue_increase_key
  import mpqik_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // The controller sequences clearing, command execution and the sweep.
  dp_cmd_t cmd;
  // The datapath reports the ends of clearing and sweep and whether an increase-key is in work.
  dp_sts_t sts;

  mpqik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entry memory, the count and the cached maximum.
  mpqik_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Checks the bounded max-priority queue one transaction at a time.
// A directed table comes first, then a random run in three phases:
// a mixed phase, a fill phase that drives the queue to full, and a
// drain-heavy phase. Every accepted input updates a software copy of
// the queue. That copy gives the result that the output side expects next.
module testbench;
  import mpqik_pkg::*;

  localparam int RANDOM_TOTAL = 1425;
  localparam int SETTLE_CYCLES = 1100;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  max_priority_queue_increase_key DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Software copy of the queue contents.
  logic signed [KEY_W-1:0] q_key [CAPACITY];
  bit                      q_used [CAPACITY];
  int                      q_count;

  out_item_t result_q[$];
  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  full_hits;
  int  empty_hits;
  int  ignored_hits;
  bit  no_idle;

  // Finds the lowest used slot that holds the largest key.
  function automatic bit top_slot(output int where);
    bit found;
    found = 0;
    where = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (q_used[i] && (!found || q_key[i] > q_key[where])) begin
        where = i;
        found = 1;
      end
    end
    return found;
  endfunction

  // Applies one command to the software queue and returns its result.
  task automatic queue_apply(input in_item_t t, output out_item_t r);
    int pos;
    r = '0;
    case (t.cmd)
      CMD_INSERT: begin
        if (q_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (q_used[pos]) pos++;
          q_used[pos] = 1;
          q_key[pos] = t.value;
          q_count++;
          r.handle = pos[SLOT_W-1:0];
        end
      end
      CMD_EXTRACT: begin
        if (top_slot(pos)) begin
          r.handle = pos[SLOT_W-1:0];
          r.result_value = q_key[pos];
          q_used[pos] = 0;
          q_count--;
        end else begin
          r.result_value = -1;
          r.status = ST_EMPTY;
        end
      end
      CMD_INCREASE: begin
        r.handle = t.slot;
        if (!q_used[t.slot] || t.value < q_key[t.slot]) begin
          r.status = ST_IGNORED;
        end else begin
          q_key[t.slot] = t.value;
        end
      end
      default: ;
    endcase
    r.top_value = top_slot(pos) ? q_key[pos] : -1;
    r.entry_total = q_count[COUNT_W-1:0];
    r.is_empty = (q_count == 0);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_EMPTY) empty_hits++;
    if (r.status == ST_IGNORED) ignored_hits++;
  endtask

  // Presents one transaction and waits for its acceptance. The valid line
  // is only lowered when a gap is taken, so back-to-back items keep it high.
  // When a typed result is given it replaces the computed one.
  task automatic send_item(input in_item_t t, input bit use_typed, input out_item_t typed);
    out_item_t r;
    int gap;
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_apply(t, r);
    result_q.insert(result_q.size(), use_typed ? typed : r);
    items_sent++;
  endtask

  // The receiver stalls at random except during the quiet stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = result_q.pop_front();
        if (out_data.handle !== e.handle || out_data.result_value !== e.result_value ||
            out_data.status !== e.status || out_data.top_value !== e.top_value ||
            out_data.entry_total !== e.entry_total || out_data.is_empty !== e.is_empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_seen);
            $display("  expected handle %0d value %0d status %0d top %0d total %0d empty %0d",
                     e.handle, e.result_value, e.status, e.top_value, e.entry_total,
                     e.is_empty);
            $display("  actual   handle %0d value %0d status %0d top %0d total %0d empty %0d",
                     out_data.handle, out_data.result_value, out_data.status,
                     out_data.top_value, out_data.entry_total, out_data.is_empty);
          end
        end
      end
    end
  end

  // A value drawn from the extremes, a narrow band (to force ties) or anywhere.
  function automatic logic signed [KEY_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return {1'b0, {(KEY_W-1){1'b1}}};
    if (r < 14) return {1'b1, {(KEY_W-1){1'b0}}};
    if (r < 40) return $signed($urandom_range(0, 15)) - 8;
    return $urandom();
  endfunction

  // Builds an increase-key: mostly aimed at a used slot with a key that is
  // larger, equal or smaller, sometimes at any slot at all.
  function automatic in_item_t pick_increase();
    in_item_t t;
    int start;
    int pos;
    longint k;
    longint nv;
    int r;
    t.cmd = CMD_INCREASE;
    t.slot = $urandom_range(0, CAPACITY - 1);
    t.value = pick_value();
    if (q_count == 0 || $urandom_range(0, 99) < 15) return t;
    start = $urandom_range(0, CAPACITY - 1);
    for (int i = 0; i < CAPACITY; i++) begin
      pos = (start + i) % CAPACITY;
      if (q_used[pos]) break;
    end
    t.slot = pos[SLOT_W-1:0];
    k = q_key[pos];
    r = $urandom_range(0, 99);
    if (r < 60) nv = k + $urandom_range(1, 1000);
    else if (r < 75) nv = k;
    else nv = k - $urandom_range(1, 1000);
    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
    t.value = nv[KEY_W-1:0];
    return t;
  endfunction

  // Draws a random command with the given weights (percent) for insert,
  // extract and increase; the rest are the unused command code.
  function automatic in_item_t pick_item(input int w_ins, input int w_ext, input int w_inc);
    in_item_t t;
    int r;
    r = $urandom_range(0, 99);
    t.value = pick_value();
    t.slot = $urandom_range(0, CAPACITY - 1);
    if (r < w_ins) t.cmd = CMD_INSERT;
    else if (r < w_ins + w_ext) t.cmd = CMD_EXTRACT;
    else if (r < w_ins + w_ext + w_inc) t = pick_increase();
    else t.cmd = CMD_NOP;
    return t;
  endfunction

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } step_row_t;

  localparam logic signed [KEY_W-1:0] KMAX = 32'sh7fffffff;
  localparam logic signed [KEY_W-1:0] KMIN = 32'sh80000000;

  step_row_t steps[$];

  // Appends one row to the directed table.
  task automatic add_step(input in_item_t stim, input bit typed, input out_item_t want);
    step_row_t row;
    row.stim = stim;
    row.typed = typed;
    row.want = want;
    steps.insert(steps.size(), row);
  endtask

  initial begin
    int n;
    out_item_t none;
    none = '0;
    rst = 1'b1;
    clk = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    no_idle = 0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    full_hits = 0;
    empty_hits = 0;
    ignored_hits = 0;
    q_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      q_used[i] = 0;
      q_key[i] = 0;
    end

    // Directed table. Rows with a typed result are the empty-queue cases and
    // the first inserts of the extreme keys; the rest come from the copy.
    add_step('{CMD_EXTRACT, 32'sd0, 10'd0}, 1,
             '{10'd0, -32'sd1, ST_EMPTY, -32'sd1, 11'd0, 1'b1});
    add_step('{CMD_INCREASE, 32'sd9, 10'd0}, 1,
             '{10'd0, 32'sd0, ST_IGNORED, -32'sd1, 11'd0, 1'b1});
    add_step('{CMD_NOP, 32'sd0, 10'd0}, 1,
             '{10'd0, 32'sd0, ST_DONE, -32'sd1, 11'd0, 1'b1});
    add_step('{CMD_INSERT, KMAX, 10'd0}, 1,
             '{10'd0, 32'sd0, ST_DONE, KMAX, 11'd1, 1'b0});
    add_step('{CMD_INSERT, KMIN, 10'h3ff}, 1,
             '{10'd1, 32'sd0, ST_DONE, KMAX, 11'd2, 1'b0});
    add_step('{CMD_INSERT, 32'sd5, 10'd0}, 0, none);
    // Two slots now hold the largest key; extract must free the lower one.
    add_step('{CMD_INSERT, KMAX, 10'd0}, 0, none);
    add_step('{CMD_EXTRACT, 32'sd0, 10'd0}, 0, none);
    add_step('{CMD_INCREASE, KMIN + 1, 10'd1}, 0, none);
    // Equal key counts as an increase; a smaller one is ignored.
    add_step('{CMD_INCREASE, 32'sd5, 10'd2}, 0, none);
    add_step('{CMD_INCREASE, 32'sd4, 10'd2}, 0, none);
    // Increases on a freed slot and on a slot never used.
    add_step('{CMD_INCREASE, KMAX, 10'd0}, 0, none);
    add_step('{CMD_INCREASE, KMAX, 10'h3ff}, 0, none);
    add_step('{CMD_INSERT, -32'sd1, 10'd0}, 0, none);
    add_step('{CMD_INCREASE, KMAX, 10'd1}, 0, none);
    add_step('{CMD_EXTRACT, 32'sd0, 10'd0}, 0, none);
    add_step('{CMD_NOP, -32'sd1, 10'h3ff}, 0, none);
    for (int i = 0; i < 4; i++) add_step('{CMD_EXTRACT, 32'sd0, 10'd0}, 0, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) send_item(steps[i].stim, steps[i].typed, steps[i].want);

    // Mixed phase; part of it runs with neither side idling.
    for (n = 0; n < 250; n++) begin
      no_idle = (n >= 100 && n < 220);
      send_item(pick_item(45, 30, 20), 0, none);
    end
    no_idle = 0;

    // Hold the input off until the queue has delivered everything owed.
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);

    // Fill phase: mostly inserts until full has been reported a few times.
    while (full_hits < 4) begin
      send_item(pick_item(90, 4, 5), 0, none);
      n++;
    end

    // Drain-heavy phase to finish the run.
    while (n < RANDOM_TOTAL) begin
      send_item(pick_item(20, 60, 15), 0, none);
      n++;
    end
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_seen, mismatches);
    $display("status coverage: %0d full inserts, %0d empty extracts, %0d ignored increases",
             full_hits, empty_hits, ignored_hits);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Each transaction runs a full sweep of the entry memory; this bound is
  // several times the slowest correct run.
  initial begin
    #80000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* files.f */
src/mpqik_pkg.sv
src/mpqik_ctrl.sv
src/mpqik_dp.sv
src/max_priority_queue_increase_key.sv
tb/testbench.sv
